### rtl/abld_pkg.sv
package abld_pkg;

	localparam int NUM_SCALES_DEF      = 3;
	localparam int SIZES_PER_SCALE_DEF = 2;
	localparam int MAX_ANCHORS_DEF     = 32768;

	localparam logic [2:0] PART_BOX  = 3'd0;
	localparam logic [2:0] PART_LAST = 3'd5;

	localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_NET_WIDTH       = 3'd1;
	localparam logic [2:0] REG_NET_HEIGHT      = 3'd2;
	localparam logic [2:0] REG_SCALE_X         = 3'd3;
	localparam logic [2:0] REG_SCALE_Y         = 3'd4;
	localparam logic [2:0] REG_CENTER_VARIANCE = 3'd5;
	localparam logic [2:0] REG_SIZE_VARIANCE   = 3'd6;
	localparam logic [2:0] REG_BOX_LIMIT       = 3'd7;

	localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd32768;
	localparam logic [10:0] RST_NET_SIZE        = 11'd640;
	localparam logic [15:0] RST_SCALE           = 16'd256;
	localparam logic [15:0] RST_CENTER_VARIANCE = 16'd6554;
	localparam logic [15:0] RST_SIZE_VARIANCE   = 16'd13107;
	localparam logic [14:0] RST_BOX_LIMIT       = 15'd5000;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] EXP_C1    = 17'd45600;
	localparam logic [16:0] EXP_C2    = 17'd14752;
	localparam logic [16:0] EXP_C3    = 17'd5184;
	localparam logic [16:0] EXP_ONE   = 17'd65536;

	localparam logic signed [41:0] COORD_MAX = 42'sd131071;
	localparam logic signed [41:0] COORD_MIN = -42'sd131072;

	// anchor grid length along one axis: ceil(net / step), net clamped to [8,1024]
	function automatic logic [8:0] grid_len(logic [10:0] net, logic [1:0] level);
		logic [11:0] n;
		logic [11:0] sum;
		n = {1'b0, net};
		if (n < 12'd8)
			n = 12'd8;
		if (n > 12'd1024)
			n = 12'd1024;
		sum = n + (12'd8 << level) - 12'd1;
		grid_len = 9'(sum >> (3'd3 + {1'b0, level}));
	endfunction

	// additive constant of each Horner round of the 2^f polynomial
	function automatic logic [16:0] poly_const(logic [1:0] round);
		case (round)
			2'd0:    poly_const = EXP_C2;
			2'd1:    poly_const = EXP_C1;
			default: poly_const = EXP_ONE;
		endcase
	endfunction

	// prior size times 2^n times polynomial, Q.16, right shift rounds half up
	function automatic logic [47:0] grow_size(logic [16:0] p, logic signed [7:0] n,
		logic [3:0] k);
		logic [47:0] v;
		logic [7:0]  neg;
		logic [5:0]  s;
		v = 48'(p) << k;
		neg = 8'(-n);
		s = neg[5:0];
		if (!n[7])
			grow_size = v << n[5:0];
		else
			grow_size = (v + (48'd1 << (s - 6'd1))) >> s;
	endfunction

endpackage

### rtl/anchor_box_landmark_decoder.sv
// Prior-box and landmark decoder for a three-level face detector.
// Input channel (in_valid/in_stall): six transactions per anchor, a box beat
// (beat_part 0: confidence, dx, dy, dw, dh) then landmark beats 1 to 5.
// A beat out of the expected order is taken and dropped without effect.
// Output channel (out_valid/out_stall): a kept anchor yields one transaction
// per beat: box corners first, then five landmark points, the fifth marked
// by anchor_last. Coordinates are image pixels in Q13.4, saturated.
// Timing: every multiplication uses one shared 24x17 multiplier under a step
// sequencer. Kept box beats run the center, log, exponent, polynomial, size,
// sum and pixel steps, kept landmark beats center, sum and pixel; beats with
// no result keep the FSM idle. in_stall is high while a transaction is in work.
// A finished result waits in the output register while out_stall is high;
// the next beat is accepted meanwhile and its work stops before the output
// load until the register frees.
// Configuration writes (cfg_we) take effect at once; write only while idle.
// Reset restores register defaults and starts a new frame at anchor zero.
module anchor_box_landmark_decoder import abld_pkg::*; #(
	parameter int NUM_SCALES      = NUM_SCALES_DEF,
	parameter int SIZES_PER_SCALE = SIZES_PER_SCALE_DEF,
	parameter int MAX_ANCHORS     = MAX_ANCHORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         beat_part,
	input  logic [15:0]        confidence,
	input  logic signed [15:0] delta_a,
	input  logic signed [15:0] delta_b,
	input  logic signed [15:0] delta_c,
	input  logic signed [15:0] delta_d,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         out_part,
	output logic [14:0]        anchor_number,
	output logic signed [17:0] coord_x1,
	output logic signed [17:0] coord_y1,
	output logic signed [17:0] coord_x2,
	output logic signed [17:0] coord_y2,
	output logic [15:0]        box_score,
	output logic               anchor_last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int AW = $clog2(MAX_ANCHORS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CTR, S_LOGA, S_LOGT, S_POLY, S_SIZE, S_SUM, S_PIX, S_OUT
	} state_t;

	// configuration
	logic [15:0] thr_q, sclx_q, scly_q, cvar_q, svar_q;
	logic [10:0] netw_q, neth_q;
	logic [14:0] limit_q;

	// anchor walker
	logic [AW-1:0] anchor_q;
	logic [1:0]    level_q, size_q;
	logic [7:0]    row_q, col_q;
	logic          kept_q;
	logic [15:0]   kcount_q;
	logic [2:0]    expect_q;
	logic [15:0]   score_q;

	// sequencer
	state_t     state_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;

	// job and datapath
	logic [2:0]         part_q;
	logic [14:0]        num_q;
	logic [1:0]         jlvl_q, jsize_q;
	logic [7:0]         jrow_q, jcol_q;
	logic signed [15:0] da_q, db_q, dc_q, dd_q;
	logic signed [35:0] px_q, py_q;
	logic signed [20:0] aw_q, ah_q;
	logic signed [7:0]  nw_q, nh_q;
	logic [15:0]        fw_q, fh_q;
	logic [16:0]        pw_q, ph_q;
	logic [47:0]        w_q, h_q;
	logic [47:0]        qc_q [4];
	logic signed [40:0] acc_q;
	logic [17:0]        res_q [4];
	logic [2:0]         opart_q;
	logic [14:0]        onum_q;
	logic [17:0]        ox1_q, oy1_q, ox2_q, oy2_q;
	logic [15:0]        oscore_q;
	logic               olast_q;

	logic               in_acc, match, keep, emit;
	logic [AW-1:0]      anc_inc, nxt_anchor;
	logic [8:0]         col_inc, row_inc;
	logic [2:0]         lvl_inc, sz_inc;
	logic [1:0]         nxt_level, nxt_size;
	logic [7:0]         nxt_row, nxt_col;
	logic               frame_end;

	logic signed [23:0] mul_a;
	logic [16:0]        mul_b;
	logic signed [41:0] prod;
	logic [3:0]         jk;
	logic [1:0]         pidx;
	logic               pix_last;
	logic signed [55:0] off_full, off_sh;
	logic [35:0]        cbase;
	logic signed [41:0] r12, r16;
	logic [38:0]        lo_rnd;
	logic signed [41:0] pixv;
	logic [17:0]        pix_sat;
	logic [47:0]        px2, py2;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign match    = (beat_part == expect_q);
	assign keep     = (kcount_q <= {1'b0, limit_q}) && (confidence >= thr_q);
	assign emit     = match && ((beat_part == PART_BOX) ? keep : kept_q);

	// walker step at the end of an anchor
	always_comb begin
		anc_inc    = anchor_q + 1'b1;
		sz_inc     = {1'b0, size_q} + 3'd1;
		col_inc    = {1'b0, col_q} + 9'd1;
		row_inc    = {1'b0, row_q} + 9'd1;
		lvl_inc    = {1'b0, level_q} + 3'd1;
		nxt_anchor = anc_inc;
		nxt_size   = size_q;
		nxt_col    = col_q;
		nxt_row    = row_q;
		nxt_level  = level_q;
		frame_end  = 1'b0;
		if (anc_inc >= AW'(MAX_ANCHORS)) begin
			frame_end = 1'b1;
		end else if (sz_inc < 3'(SIZES_PER_SCALE)) begin
			nxt_size = sz_inc[1:0];
		end else begin
			nxt_size = 2'd0;
			if (col_inc < grid_len(netw_q, level_q)) begin
				nxt_col = col_inc[7:0];
			end else begin
				nxt_col = 8'd0;
				if (row_inc < grid_len(neth_q, level_q)) begin
					nxt_row = row_inc[7:0];
				end else begin
					nxt_row = 8'd0;
					if (lvl_inc < 3'(NUM_SCALES))
						nxt_level = lvl_inc[1:0];
					else
						frame_end = 1'b1;
				end
			end
		end
		if (frame_end) begin
			nxt_anchor = '0;
			nxt_size   = 2'd0;
			nxt_col    = 8'd0;
			nxt_row    = 8'd0;
			nxt_level  = 2'd0;
		end
	end

	// shared multiplier operand select
	assign pidx     = cnt_q[2:1];
	assign pix_last = (part_q == PART_BOX) ? (cnt_q == 3'd7) : (cnt_q == 3'd3);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CTR: begin
				mul_a = 24'(cnt_q[0] ? db_q : da_q);
				mul_b = {1'b0, cvar_q};
			end
			S_LOGA: begin
				mul_a = 24'(cnt_q[0] ? dd_q : dc_q);
				mul_b = {1'b0, svar_q};
			end
			S_LOGT: begin
				mul_a = 24'(cnt_q[0] ? ah_q : aw_q);
				mul_b = LOG2E_Q16;
			end
			S_POLY: begin
				mul_a = {7'd0, (cnt_q[0] ? ph_q : pw_q)};
				mul_b = {1'b0, (cnt_q[0] ? fh_q : fw_q)};
			end
			S_PIX: begin
				if (cnt_q[0])
					mul_a = {3'd0, qc_q[pidx][20:0]};
				else
					mul_a = qc_q[pidx][44:21];
				mul_b = {1'b0, (pidx[0] ? scly_q : sclx_q)};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * $signed({1'b0, mul_b});

	// post-processing of the product
	always_comb begin
		jk       = 4'd4 + {1'b0, jlvl_q, 1'b0} + {2'd0, jsize_q};
		off_full = {{14{prod[41]}}, prod} <<< jk;
		off_sh   = (off_full + 56'sd2048) >>> 12;
		cbase    = 36'({(cnt_q[0] ? jrow_q : jcol_q), 1'b1}) << (5'd18 + {3'd0, jlvl_q});
		r12      = (prod + 42'sd2048) >>> 12;
		r16      = (prod + 42'sd32768) >>> 16;
		lo_rnd   = {1'b0, prod[37:0]} + 39'h100000;
		pixv     = {{1{acc_q[40]}}, acc_q} + $signed({24'd0, lo_rnd[38:21]});
		if (pixv > COORD_MAX)
			pix_sat = 18'h1FFFF;
		else if (pixv < COORD_MIN)
			pix_sat = 18'h20000;
		else
			pix_sat = pixv[17:0];
		px2 = {{11{px_q[35]}}, px_q, 1'b0};
		py2 = {{11{py_q[35]}}, py_q, 1'b0};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= RST_SCORE_THRESHOLD;
			netw_q  <= RST_NET_SIZE;
			neth_q  <= RST_NET_SIZE;
			sclx_q  <= RST_SCALE;
			scly_q  <= RST_SCALE;
			cvar_q  <= RST_CENTER_VARIANCE;
			svar_q  <= RST_SIZE_VARIANCE;
			limit_q <= RST_BOX_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCORE_THRESHOLD: thr_q   <= cfg_data;
				REG_NET_WIDTH:       netw_q  <= cfg_data[10:0];
				REG_NET_HEIGHT:      neth_q  <= cfg_data[10:0];
				REG_SCALE_X:         sclx_q  <= cfg_data;
				REG_SCALE_Y:         scly_q  <= cfg_data;
				REG_CENTER_VARIANCE: cvar_q  <= cfg_data;
				REG_SIZE_VARIANCE:   svar_q  <= cfg_data;
				REG_BOX_LIMIT:       limit_q <= cfg_data[14:0];
				default:             thr_q   <= thr_q;
			endcase
		end
	end

	// sequencer, walker and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
			anchor_q    <= '0;
			level_q     <= 2'd0;
			row_q       <= 8'd0;
			col_q       <= 8'd0;
			size_q      <= 2'd0;
			kept_q      <= 1'b0;
			kcount_q    <= 16'd0;
			expect_q    <= PART_BOX;
			score_q     <= 16'd0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && match) begin
						if (beat_part == PART_BOX) begin
							kept_q   <= keep;
							expect_q <= 3'd1;
							if (keep) begin
								kcount_q <= kcount_q + 16'd1;
								score_q  <= confidence;
							end
						end else if (beat_part == PART_LAST) begin
							expect_q <= PART_BOX;
							kept_q   <= 1'b0;
							anchor_q <= nxt_anchor;
							level_q  <= nxt_level;
							row_q    <= nxt_row;
							col_q    <= nxt_col;
							size_q   <= nxt_size;
							if (frame_end)
								kcount_q <= 16'd0;
						end else begin
							expect_q <= beat_part + 3'd1;
						end
						if (emit) begin
							state_q <= S_CTR;
							cnt_q   <= 3'd0;
						end
					end
				end
				S_CTR: begin
					if (cnt_q[0]) begin
						cnt_q   <= 3'd0;
						state_q <= (part_q == PART_BOX) ? S_LOGA : S_SUM;
					end else begin
						cnt_q <= 3'd1;
					end
				end
				S_LOGA: begin
					if (cnt_q[0]) begin
						cnt_q   <= 3'd0;
						state_q <= S_LOGT;
					end else begin
						cnt_q <= 3'd1;
					end
				end
				S_LOGT: begin
					if (cnt_q[0]) begin
						cnt_q   <= 3'd0;
						state_q <= S_POLY;
					end else begin
						cnt_q <= 3'd1;
					end
				end
				S_POLY: begin
					if (cnt_q == 3'd5) begin
						cnt_q   <= 3'd0;
						state_q <= S_SIZE;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_SIZE: state_q <= S_SUM;
				S_SUM: begin
					cnt_q   <= 3'd0;
					state_q <= S_PIX;
				end
				S_PIX: begin
					if (pix_last) begin
						cnt_q   <= 3'd0;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			part_q  <= beat_part;
			num_q   <= 15'(anchor_q);
			jlvl_q  <= level_q;
			jsize_q <= size_q;
			jrow_q  <= row_q;
			jcol_q  <= col_q;
			da_q    <= delta_a;
			db_q    <= delta_b;
			dc_q    <= delta_c;
			dd_q    <= delta_d;
		end
		case (state_q)
			S_CTR: begin
				if (cnt_q[0])
					py_q <= $signed(cbase) + off_sh[35:0];
				else
					px_q <= $signed(cbase) + off_sh[35:0];
			end
			S_LOGA: begin
				if (cnt_q[0])
					ah_q <= r12[20:0];
				else
					aw_q <= r12[20:0];
			end
			S_LOGT: begin
				if (cnt_q[0]) begin
					nh_q <= r16[23:16];
					fh_q <= r16[15:0];
					ph_q <= EXP_C3;
				end else begin
					nw_q <= r16[23:16];
					fw_q <= r16[15:0];
					pw_q <= EXP_C3;
				end
			end
			S_POLY: begin
				if (cnt_q[0])
					ph_q <= prod[32:16] + poly_const(pidx);
				else
					pw_q <= prod[32:16] + poly_const(pidx);
			end
			S_SIZE: begin
				w_q <= grow_size(pw_q, nw_q, jk);
				h_q <= grow_size(ph_q, nh_q, jk);
			end
			S_SUM: begin
				if (part_q == PART_BOX) begin
					qc_q[0] <= px2 - w_q;
					qc_q[1] <= py2 - h_q;
					qc_q[2] <= px2 + w_q;
					qc_q[3] <= py2 + h_q;
				end else begin
					qc_q[0] <= px2;
					qc_q[1] <= py2;
				end
			end
			S_PIX: begin
				if (cnt_q[0])
					res_q[pidx] <= pix_sat;
				else
					acc_q <= prod[40:0];
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					opart_q  <= part_q;
					onum_q   <= num_q;
					ox1_q    <= res_q[0];
					oy1_q    <= res_q[1];
					ox2_q    <= (part_q == PART_BOX) ? res_q[2] : 18'd0;
					oy2_q    <= (part_q == PART_BOX) ? res_q[3] : 18'd0;
					oscore_q <= score_q;
					olast_q  <= (part_q == PART_LAST);
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign out_part      = opart_q;
	assign anchor_number = onum_q;
	assign coord_x1      = $signed(ox1_q);
	assign coord_y1      = $signed(oy1_q);
	assign coord_x2      = $signed(ox2_q);
	assign coord_y2      = $signed(oy2_q);
	assign box_score     = oscore_q;
	assign anchor_last   = olast_q;

endmodule

### dv/anchor_box_landmark_decoder_checker.sv
module anchor_box_landmark_decoder_checker import abld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         beat_part,
	input  logic [15:0]        confidence,
	input  logic signed [15:0] delta_a,
	input  logic signed [15:0] delta_b,
	input  logic signed [15:0] delta_c,
	input  logic signed [15:0] delta_d,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         out_part,
	input  logic [14:0]        anchor_number,
	input  logic signed [17:0] coord_x1,
	input  logic signed [17:0] coord_y1,
	input  logic signed [17:0] coord_x2,
	input  logic signed [17:0] coord_y2,
	input  logic [15:0]        box_score,
	input  logic               anchor_last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 boxes_seen,
	output int                 points_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  part;
		logic [14:0] anchor;
		logic [17:0] x1;
		logic [17:0] y1;
		logic [17:0] x2;
		logic [17:0] y2;
		logic [15:0] score;
		logic        last;
	} decoded_t;

	decoded_t decoded_q[$];

	logic [15:0] thr, scl_x, scl_y, cvar, svar;
	logic [10:0] net_w, net_h;
	logic [14:0] limit;
	int unsigned anchor_idx, level, row, col, size_sel, kept_cnt, want_part;
	logic        keeping;
	logic [15:0] score_hold;

	assign pending = decoded_q.size();

	// divide by 2^s, round half up
	function automatic longint round_shift(longint v, int s);
		v += longint'(1) <<< (s - 1);
		if (v >= 0)
			return v >>> s;
		return -((-v + ((longint'(1) <<< s) - 1)) >>> s);
	endfunction

	function automatic int unsigned cells(logic [10:0] net, int unsigned lv);
		int unsigned n, stp;
		n = net;
		stp = 8 << lv;
		if (n < 8) n = 8;
		if (n > 1024) n = 1024;
		return (n + stp - 1) / stp;
	endfunction

	function automatic logic [17:0] pixel(longint q17, logic [15:0] s);
		longint v;
		v = round_shift(q17 * longint'(s), 21);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[17:0];
	endfunction

	// prior size times exp(d * size variance), Q.16
	function automatic longint exp_size(longint d, longint m);
		longint a, t, n, f, p, v;
		a = round_shift(d * longint'(svar), 12);
		t = round_shift(a * 94548, 16);
		n = (t >= 0) ? t / 65536 : -((-t + 65535) / 65536);
		f = t - n * 65536;
		p = 5184;
		p = ((p * f) >> 16) + 14752;
		p = ((p * f) >> 16) + 45600;
		p = ((p * f) >> 16) + 65536;
		v = m * p;
		if (n >= 0)
			v = v << n;
		else
			v = (v + (longint'(1) << (-n - 1))) >> (-n);
		return v;
	endfunction

	task automatic restart_frame();
		anchor_idx = 0; level = 0; row = 0; col = 0; size_sel = 0; kept_cnt = 0;
	endtask

	task automatic next_anchor();
		anchor_idx++;
		if (anchor_idx >= MAX_ANCHORS_DEF) begin
			restart_frame();
			return;
		end
		if (++size_sel < SIZES_PER_SCALE_DEF) return;
		size_sel = 0;
		if (++col < cells(net_w, level)) return;
		col = 0;
		if (++row < cells(net_h, level)) return;
		row = 0;
		if (++level < NUM_SCALES_DEF) return;
		restart_frame();
	endtask

	task automatic decode_beat();
		longint stp, m, cx, cy, px, py, w, h;
		decoded_t r;
		if (beat_part != want_part[2:0] || beat_part > PART_LAST)
			return;
		stp = 8 << level;
		m = 16 << (2 * level + size_sel);
		cx = (2 * col + 1) * stp * 32768;
		cy = (2 * row + 1) * stp * 32768;
		px = cx + round_shift(longint'(delta_a) * longint'(cvar) * m, 12);
		py = cy + round_shift(longint'(delta_b) * longint'(cvar) * m, 12);
		r = '0;
		r.part = beat_part;
		r.anchor = anchor_idx[14:0];
		if (beat_part == PART_BOX) begin
			keeping = 1'b0;
			if (kept_cnt <= limit && confidence >= thr) begin
				keeping = 1'b1;
				kept_cnt++;
				score_hold = confidence;
				w = exp_size(longint'(delta_c), m);
				h = exp_size(longint'(delta_d), m);
				r.x1 = pixel(2 * px - w, scl_x);
				r.y1 = pixel(2 * py - h, scl_y);
				r.x2 = pixel(2 * px + w, scl_x);
				r.y2 = pixel(2 * py + h, scl_y);
				r.score = score_hold;
				decoded_q = {decoded_q, r};
			end
			want_part = 1;
		end else begin
			if (keeping) begin
				r.x1 = pixel(2 * px, scl_x);
				r.y1 = pixel(2 * py, scl_y);
				r.score = score_hold;
				r.last = (beat_part == PART_LAST);
				decoded_q = {decoded_q, r};
			end
			if (beat_part == PART_LAST) begin
				want_part = 0;
				keeping = 1'b0;
				next_anchor();
			end else begin
				want_part = beat_part + 1;
			end
		end
	endtask

	task automatic compare_result();
		decoded_t e, a;
		a = '{out_part, anchor_number, coord_x1, coord_y1, coord_x2, coord_y2,
			box_score, anchor_last};
		if (decoded_q.size() == 0) begin
			$display("%0t: unexpected result %p", $time, a);
			fail_count++;
			return;
		end
		e = decoded_q.pop_front();
		if (e != a) begin
			$display("%0t: mismatch expected %p", $time, e);
			$display("%0t:          actual   %p", $time, a);
			fail_count++;
		end
		if (a.part == PART_BOX)
			boxes_seen++;
		else
			points_seen++;
	endtask

	initial begin
		fail_count = 0;
		boxes_seen = 0;
		points_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr = RST_SCORE_THRESHOLD; net_w = RST_NET_SIZE; net_h = RST_NET_SIZE;
			scl_x = RST_SCALE; scl_y = RST_SCALE; cvar = RST_CENTER_VARIANCE;
			svar = RST_SIZE_VARIANCE; limit = RST_BOX_LIMIT;
			restart_frame();
			keeping = 1'b0; want_part = 0; score_hold = '0;
			decoded_q.delete();
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (cfg_we) begin
				case (cfg_index)
					REG_SCORE_THRESHOLD: thr = cfg_data;
					REG_NET_WIDTH:       net_w = cfg_data[10:0];
					REG_NET_HEIGHT:      net_h = cfg_data[10:0];
					REG_SCALE_X:         scl_x = cfg_data;
					REG_SCALE_Y:         scl_y = cfg_data;
					REG_CENTER_VARIANCE: cvar = cfg_data;
					REG_SIZE_VARIANCE:   svar = cfg_data;
					REG_BOX_LIMIT:       limit = cfg_data[14:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_beat();
		end
	end

endmodule

### dv/anchor_box_landmark_decoder_tb.sv
module anchor_box_landmark_decoder_tb import abld_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid, in_stall;
	logic [2:0]         beat_part;
	logic [15:0]        confidence;
	logic signed [15:0] delta_a, delta_b, delta_c, delta_d;
	logic               out_valid, out_stall;
	logic [2:0]         out_part;
	logic [14:0]        anchor_number;
	logic signed [17:0] coord_x1, coord_y1, coord_x2, coord_y2;
	logic [15:0]        box_score;
	logic               anchor_last;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	int fail_count, pending, boxes_seen, points_seen;
	int beats_sent, idle_cycles;
	bit no_gaps;
	logic [15:0] cur_thr;

	anchor_box_landmark_decoder dut (.*);

	anchor_box_landmark_decoder_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog: stop when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress", $time);
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: short stalls mostly, some long, one long hold-off early
	task automatic rx_burst();
		int free, busy, r;
		r = $urandom_range(0, 19);
		free = (r == 0) ? $urandom_range(100, 250) : $urandom_range(1, 20);
		repeat (free) @(negedge clk) out_stall <= 1'b0;
		r = $urandom_range(0, 9);
		busy = (r < 7) ? $urandom_range(1, 3) : (r < 9) ? $urandom_range(4, 20)
			: $urandom_range(30, 120);
		repeat (busy) @(negedge clk) out_stall <= 1'b1;
	endtask

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		repeat (500) @(negedge clk) out_stall <= 1'b0;
		repeat (300) @(negedge clk) out_stall <= 1'b1;
		forever rx_burst();
	end

	task automatic send_beat(logic [2:0] part, logic [15:0] conf, logic [15:0] a,
		logic [15:0] b, logic [15:0] c, logic [15:0] d);
		int r, gap;
		@(negedge clk);
		in_valid <= 1'b1;
		beat_part <= part;
		confidence <= conf;
		delta_a <= a; delta_b <= b; delta_c <= c; delta_d <= d;
		forever begin
			#1;
			if (!in_stall) break;
			@(negedge clk);
		end
		@(posedge clk);
		beats_sent++;
		r = $urandom_range(0, 9);
		gap = (no_gaps || r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3)
			: $urandom_range(10, 60);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [15:0] rand_delta();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 16'($signed($urandom_range(0, 4095)) - 2048);
		if (r < 8) return 16'($signed($urandom_range(0, 32767)) - 16384);
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] rand_conf();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return cur_thr;
		if (r == 1) return cur_thr - 16'd1;
		return 16'($urandom);
	endfunction

	task automatic send_anchor(logic [15:0] conf);
		send_beat(PART_BOX, conf, rand_delta(), rand_delta(), rand_delta(), rand_delta());
		for (int p = 1; p <= 5; p++)
			send_beat(3'(p), 16'($urandom), rand_delta(), rand_delta(), 16'($urandom),
				16'($urandom));
	endtask

	// mostly clean anchors, with stray and skipped beats mixed in
	task automatic random_phase(int anchors);
		int r;
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < anchors; i++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_beat(3'($urandom_range(1, 7)), 16'($urandom), rand_delta(),
					rand_delta(), rand_delta(), rand_delta());
			if (r == 1) begin
				send_beat(PART_BOX, rand_conf(), rand_delta(), rand_delta(),
					rand_delta(), rand_delta());
				send_beat(3'd3, 16'($urandom), rand_delta(), rand_delta(), 16'h0, 16'h0);
				send_beat(3'($urandom_range(6, 7)), 16'($urandom), rand_delta(),
					rand_delta(), 16'h0, 16'h0);
				for (int p = 1; p <= 5; p++)
					send_beat(3'(p), 16'($urandom), rand_delta(), rand_delta(),
						16'($urandom), 16'($urandom));
			end else begin
				send_anchor(rand_conf());
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic configure(logic [15:0] thr, logic [15:0] nw, logic [15:0] nh,
		logic [15:0] sx, logic [15:0] sy, logic [15:0] cv, logic [15:0] sv,
		logic [15:0] lim);
		logic [15:0] vals[8];
		vals = '{thr, nw, nh, sx, sy, cv, sv, lim};
		foreach (vals[i]) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
		end
		@(negedge clk) cfg_we <= 1'b0;
		cur_thr = thr;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; beat_part = '0; confidence = '0;
		delta_a = '0; delta_b = '0; delta_c = '0; delta_d = '0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		idle_cycles = 0; beats_sent = 0; no_gaps = 1'b0;
		cur_thr = RST_SCORE_THRESHOLD;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: field extremes, threshold edges, stray beats
		send_beat(PART_BOX, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		for (int p = 1; p <= 5; p++)
			send_beat(3'(p), 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
		send_beat(3'd6, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0);
		send_beat(3'd7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		send_beat(3'd2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		send_beat(PART_BOX, 16'd32768, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_beat(3'd2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
		for (int p = 1; p <= 5; p++)
			send_beat(3'(p), 16'h0, 16'h8000, 16'h7FFF, 16'h0, 16'h0);
		send_anchor(16'd32767);
		drain();

		random_phase(25);
		drain();
		configure(16'd0, 16'd8, 16'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16384);
		random_phase(40);
		drain();
		configure(16'hFFFF, 16'd1024, 16'd1024, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
		for (int i = 0; i < 10; i++)
			send_anchor(16'hFFFF);
		random_phase(25);
		drain();
		configure(16'd0, 16'h07FF, 16'd0, 16'd256, 16'd512, 16'd6554, 16'd13107, 16'd2);
		random_phase(35);
		drain();
		configure(16'd1000, 16'd8, 16'd16, 16'd300, 16'd200, 16'd20000, 16'd40000, 16'd3);
		random_phase(40);
		drain();
		configure(16'($urandom), 16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)),
			16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 16'($urandom),
			16'($urandom), 16'($urandom_range(1, 16384)));
		random_phase(40);
		drain();
		configure(16'($urandom_range(0, 40000)), 16'($urandom_range(8, 64)),
			16'($urandom_range(8, 64)), 16'($urandom_range(64, 1024)),
			16'($urandom_range(64, 1024)), 16'($urandom), 16'($urandom),
			16'($urandom_range(1, 20)));
		random_phase(20);
		drain();

		$display("Sent %0d beats over seven register settings; checked %0d boxes and %0d points",
			beats_sent, boxes_seen, points_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
